@@ rtl/bounded_deque_with_search_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque core
// Clocked property checks; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset gating
`define BDQS_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bdqs assertion failed");
// check that also holds during reset
`define BDQS_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdqs assertion failed");
`else
`define BDQS_ASSERT_RST(label, clk, rst, prop)
`define BDQS_ASSERT(label, clk, prop)
`endif

`endif

@@ rtl/bdqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared constants, codes and types of the bounded deque core.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SEARCH     = 3'd4;
  localparam logic [2:0] ACT_COUNT      = 3'd5;
  localparam logic [2:0] ACT_REVERSE    = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // per-cell control
  typedef struct packed {
    logic shift_right;  // take left neighbor (toward tail)
    logic shift_left;   // take right neighbor (toward head)
    logic load;         // take the pushed value directly
  } cell_ctl_t;

endpackage

@@ rtl/bdqs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_cell
// One storage slot of the deque row: holds an entry, shifts toward either
// neighbor, and compares its entry against the search key.
// ----------------------------------------------------------------------------
module bdqs_cell (
  input  logic                                 clk,
  input  bdqs_pkg::cell_ctl_t                  ctl,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   from_left,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   from_right,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   item_value,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   search_key,
  input  logic                                 occupied,
  output logic signed [bdqs_pkg::DATA_W-1:0]   entry,
  output logic                                 match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= item_value;
    end else if (ctl.shift_right) begin
      entry <= from_left;
    end else if (ctl.shift_left) begin
      entry <= from_right;
    end
  end

  // unoccupied slots never match, so stale data is never seen
  assign match = occupied && (entry == search_key);

endmodule

@@ rtl/bounded_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Bounded double-ended queue of signed 32-bit entries with key search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive action, item_value and search_key with start high;
//   the beat is taken on a rising edge where start is high and busy is low.
//   busy is high only while rst is high, so a command can be issued every cycle.
//   Result channel: status, found and occupancy_out appear for exactly one
//   cycle with done high, in the cycle after the command beat. The receiver
//   cannot stall; each result must be captured in its done cycle.
//   Throughput: one command per cycle. Every action,
//   search included, finishes in a single pass over the row of cells: each
//   cell compares its own entry, the matches are OR-reduced.
//   Storage is a row of CAPACITY cells kept in logical order from cell 0;
//   a push at the head or pop at the head shifts the whole row one step.
//   Reverse only toggles an orientation flag swapping front and back.
//   Reset (synchronous, rst high) empties the store, clears the flag and
//   drops done; entry contents are left as they are.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_core_assert.svh"

module bounded_deque_with_search_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           action,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   item_value,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   search_key,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic                                 found,
  output logic [bdqs_pkg::OCC_W-1:0]           occupancy_out
);

  localparam logic [bdqs_pkg::OCC_W-1:0] FULL_CNT =
    bdqs_pkg::OCC_W'(bdqs_pkg::CAPACITY);

  logic                               accept;
  logic [bdqs_pkg::OCC_W-1:0]         occupancy;
  logic [bdqs_pkg::OCC_W-1:0]         occupancy_next;
  logic                               reversed;
  logic                               reversed_next;
  logic [1:0]                         status_next;
  logic                               found_next;
  logic                               shift_r;
  logic                               shift_l;
  logic                               load_tail;
  logic                               at_head;
  logic                               any_match;

  logic signed [bdqs_pkg::DATA_W-1:0] entry [bdqs_pkg::CAPACITY];
  logic [bdqs_pkg::CAPACITY-1:0]      match;
  logic [bdqs_pkg::CAPACITY-1:0]      occupied;
  bdqs_pkg::cell_ctl_t                ctl [bdqs_pkg::CAPACITY];

  assign busy   = rst;
  assign accept = start && !busy;

  assign any_match = |match;
  assign at_head   = ((action == bdqs_pkg::ACT_PUSH_FRONT) ||
                      (action == bdqs_pkg::ACT_POP_FRONT)) != reversed;

  always_comb begin
    occupancy_next = occupancy;
    reversed_next  = reversed;
    status_next    = bdqs_pkg::ST_OK;
    found_next     = 1'b0;
    shift_r        = 1'b0;
    shift_l        = 1'b0;
    load_tail      = 1'b0;
    case (action)
      bdqs_pkg::ACT_PUSH_FRONT, bdqs_pkg::ACT_PUSH_BACK: begin
        if (occupancy == FULL_CNT) begin
          status_next = bdqs_pkg::ST_FULL;
        end else begin
          shift_r        = at_head;
          load_tail      = !at_head;
          occupancy_next = occupancy + 1'b1;
        end
      end
      bdqs_pkg::ACT_POP_FRONT, bdqs_pkg::ACT_POP_BACK: begin
        if (occupancy == '0) begin
          status_next = bdqs_pkg::ST_EMPTY;
        end else begin
          shift_l        = at_head;
          occupancy_next = occupancy - 1'b1;
        end
      end
      bdqs_pkg::ACT_SEARCH: begin
        found_next = any_match;
      end
      bdqs_pkg::ACT_REVERSE: begin
        reversed_next = !reversed;
      end
      default: begin
      end
    endcase
  end

  // row of cells, cell 0 is the physical head
  genvar gi;
  generate
    for (gi = 0; gi < bdqs_pkg::CAPACITY; gi++) begin : g_cell
      logic signed [bdqs_pkg::DATA_W-1:0] left_val;
      logic signed [bdqs_pkg::DATA_W-1:0] right_val;

      if (gi == 0) begin : g_head
        assign left_val = item_value;
      end else begin : g_mid_l
        assign left_val = entry[gi-1];
      end
      if (gi == bdqs_pkg::CAPACITY - 1) begin : g_tail
        assign right_val = entry[gi];
      end else begin : g_mid_r
        assign right_val = entry[gi+1];
      end

      assign occupied[gi] = bdqs_pkg::OCC_W'(gi) < occupancy;

      always_comb begin
        ctl[gi].shift_right = accept && shift_r;
        ctl[gi].shift_left  = accept && shift_l;
        ctl[gi].load        = accept && (load_tail && (bdqs_pkg::OCC_W'(gi) == occupancy)
                                         || shift_r && (gi == 0));
      end

      bdqs_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[gi]),
        .from_left  (left_val),
        .from_right (right_val),
        .item_value (item_value),
        .search_key (search_key),
        .occupied   (occupied[gi]),
        .entry      (entry[gi]),
        .match      (match[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      reversed  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        occupancy <= occupancy_next;
        reversed  <= reversed_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      found         <= found_next;
      occupancy_out <= occupancy_next;
    end
  end

  `BDQS_ASSERT(a_occ_bound, clk, rst || (occupancy <= FULL_CNT))
  `BDQS_ASSERT_RST(a_done_follows, clk, rst, accept |=> done)
  `BDQS_ASSERT_RST(a_full_count, clk, rst, done && (status == bdqs_pkg::ST_FULL) |-> occupancy_out == FULL_CNT)
  `BDQS_ASSERT_RST(a_empty_count, clk, rst, done && (status == bdqs_pkg::ST_EMPTY) |-> occupancy_out == '0)
  `BDQS_ASSERT_RST(a_found_ok, clk, rst, done && found |-> status == bdqs_pkg::ST_OK && occupancy_out != '0)

endmodule

@@ tb/tb_bounded_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_core
// Self-checking bench for the bounded deque core: a queue-driven command
// driver, a result monitor and a behavioral deque that predicts every beat.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_core;

  localparam logic [2:0] ACT_UNUSED  = 3'd7;
  localparam int         RANDOM_OPS  = 1500;
  localparam int         CYCLE_LIMIT = 200000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} bias_mode_t;

  typedef struct {
    logic [2:0]                         action;
    logic signed [bdqs_pkg::DATA_W-1:0] value;
    logic signed [bdqs_pkg::DATA_W-1:0] key;
    int                                 idle_pct;
  } deque_cmd_t;

  typedef struct {
    logic [1:0]                 status;
    logic                       found;
    logic [bdqs_pkg::OCC_W-1:0] occupancy;
  } deque_resp_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic [2:0]                         action = bdqs_pkg::ACT_COUNT;
  logic signed [bdqs_pkg::DATA_W-1:0] item_value = '0;
  logic signed [bdqs_pkg::DATA_W-1:0] search_key = '0;
  logic                               busy;
  logic                               done;
  logic [1:0]                         status;
  logic                               found;
  logic [bdqs_pkg::OCC_W-1:0]         occupancy_out;

  deque_cmd_t                         cmd_queue[$];
  deque_resp_t                        expected_resp[$];
  logic signed [bdqs_pkg::DATA_W-1:0] shadow_cells[$];
  bit                                 shadow_flipped = 1'b0;
  logic signed [bdqs_pkg::DATA_W-1:0] value_pool[8];
  int                                 mismatch_count = 0;
  int                                 cycle_count = 0;

  bounded_deque_with_search_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .item_value   (item_value),
    .search_key   (search_key),
    .done         (done),
    .status       (status),
    .found        (found),
    .occupancy_out(occupancy_out)
  );

  always #2 clk = ~clk;

  // Behavioral deque kept in logical order from the physical head.
  function automatic deque_resp_t apply_deque_cmd(deque_cmd_t c);
    deque_resp_t r;
    bit          at_head;
    r.status = bdqs_pkg::ST_OK;
    r.found  = 1'b0;
    case (c.action)
      bdqs_pkg::ACT_PUSH_FRONT, bdqs_pkg::ACT_PUSH_BACK: begin
        if (shadow_cells.size() >= bdqs_pkg::CAPACITY) begin
          r.status = bdqs_pkg::ST_FULL;
        end else begin
          at_head = (c.action == bdqs_pkg::ACT_PUSH_FRONT) ^ shadow_flipped;
          if (at_head) shadow_cells.push_front(c.value);
          else shadow_cells.push_back(c.value);
        end
      end
      bdqs_pkg::ACT_POP_FRONT, bdqs_pkg::ACT_POP_BACK: begin
        if (shadow_cells.size() == 0) begin
          r.status = bdqs_pkg::ST_EMPTY;
        end else begin
          at_head = (c.action == bdqs_pkg::ACT_POP_FRONT) ^ shadow_flipped;
          if (at_head) void'(shadow_cells.pop_front());
          else void'(shadow_cells.pop_back());
        end
      end
      bdqs_pkg::ACT_SEARCH: begin
        foreach (shadow_cells[i])
          if (shadow_cells[i] == c.key) r.found = 1'b1;
      end
      bdqs_pkg::ACT_REVERSE: shadow_flipped = !shadow_flipped;
      default: ;
    endcase
    r.occupancy = bdqs_pkg::OCC_W'(shadow_cells.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, int exp_val, int got_val);
    $display("MISMATCH %s at cycle %0d: expected %0d, got %0d",
             field, cycle_count, exp_val, got_val);
    mismatch_count++;
  endtask

  function automatic logic signed [bdqs_pkg::DATA_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4, 5: return value_pool[$urandom_range(7)];
      6: return $urandom;
      7: return 32'sh7fff_ffff;
      8: return 32'sh8000_0000;
      default: return ($urandom_range(1) != 0) ? -32'sd1 : 32'sd0;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(bias_mode_t mode);
    int roll;
    int push_pct;
    roll = $urandom_range(99);
    push_pct = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 15 : 35;
    if (roll == 0) return ACT_UNUSED;
    if (roll < push_pct)
      return ($urandom_range(1) != 0) ? bdqs_pkg::ACT_PUSH_BACK : bdqs_pkg::ACT_PUSH_FRONT;
    if (roll < 75 || (mode == MODE_DRAIN && roll < 85))
      return ($urandom_range(1) != 0) ? bdqs_pkg::ACT_POP_BACK : bdqs_pkg::ACT_POP_FRONT;
    if (roll < 92) return bdqs_pkg::ACT_SEARCH;
    if (roll < 96) return bdqs_pkg::ACT_REVERSE;
    return bdqs_pkg::ACT_COUNT;
  endfunction

  task automatic add_cmd(logic [2:0] act, logic signed [bdqs_pkg::DATA_W-1:0] val,
                         logic signed [bdqs_pkg::DATA_W-1:0] key, int idle_pct);
    deque_cmd_t c;
    c.action   = act;
    c.value    = val;
    c.key      = key;
    c.idle_pct = idle_pct;
    cmd_queue.push_back(c);
  endtask

  // Command driver: retires the beat taken at this edge, then offers the next.
  always @(posedge clk) begin : cmd_driver
    deque_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_resp.push_back(apply_deque_cmd(cmd_queue.pop_front()));
      if (cmd_queue.size() != 0 && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
        nxt = cmd_queue[0];
        start      <= 1'b1;
        action     <= nxt.action;
        item_value <= nxt.value;
        search_key <= nxt.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: done marks a beat that must be taken this cycle.
  always @(posedge clk) begin : resp_monitor
    deque_resp_t exp_r;
    if (!rst && done) begin
      if (expected_resp.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        exp_r = expected_resp.pop_front();
        if (status !== exp_r.status) report_mismatch("status", exp_r.status, status);
        if (found !== exp_r.found) report_mismatch("found", exp_r.found, found);
        if (occupancy_out !== exp_r.occupancy)
          report_mismatch("occupancy_out", exp_r.occupancy, occupancy_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    bias_mode_t mode;
    int         run_left;
    int         idle_pct;
    int         phase_pct[4];
    phase_pct = '{0, 69, 0, 18};
    foreach (value_pool[i]) value_pool[i] = $urandom;

    // directed: empty-store corner cases, extremes, unused code, then fill up
    add_cmd(bdqs_pkg::ACT_POP_FRONT, 0, 0, 0);
    add_cmd(bdqs_pkg::ACT_POP_BACK, 0, 0, 0);
    add_cmd(bdqs_pkg::ACT_SEARCH, 0, 0, 0);
    add_cmd(bdqs_pkg::ACT_COUNT, 0, 0, 0);
    add_cmd(bdqs_pkg::ACT_REVERSE, 0, 0, 0);
    add_cmd(bdqs_pkg::ACT_REVERSE, 0, 0, 0);
    add_cmd(ACT_UNUSED, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    add_cmd(bdqs_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff, 0, 0);
    add_cmd(bdqs_pkg::ACT_PUSH_BACK, 32'sh8000_0000, 0, 0);
    add_cmd(bdqs_pkg::ACT_SEARCH, 0, 32'sh8000_0000, 0);
    add_cmd(bdqs_pkg::ACT_SEARCH, 0, -32'sd1, 0);
    for (int i = 0; i < bdqs_pkg::CAPACITY - 2; i++)
      add_cmd(bdqs_pkg::ACT_PUSH_BACK, value_pool[i % 8], 0, 0);
    add_cmd(bdqs_pkg::ACT_PUSH_FRONT, -32'sd1, 0, 0);
    add_cmd(bdqs_pkg::ACT_PUSH_BACK, -32'sd1, 0, 0);

    // random: runs biased toward filling, draining or a mix so both ends get hit
    run_left = 0;
    mode = MODE_MIXED;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (run_left == 0) begin
        mode = bias_mode_t'($urandom_range(2));
        run_left = $urandom_range(60, 20);
      end
      run_left--;
      idle_pct = phase_pct[(n * 4) / RANDOM_OPS];
      add_cmd(pick_action(mode), pick_word(), pick_word(), idle_pct);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || expected_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
